// ----- rtl/lpg_pkg.sv -----
// ----------------------------------------------------------------------------
// lpg_pkg: shared types and constants
// Widths, register-file write command and sequencer states for the
// lexicographic permutation generator.
// ----------------------------------------------------------------------------
package lpg_pkg;

  localparam int ELEM_W        = 3;   // value width of one element
  localparam int IDX_W         = 3;   // position index width (up to 8 positions)
  localparam int SIZE_W        = 4;   // perm_size register width
  localparam int RANK_W        = 16;  // running rank width
  localparam int NUM_OUT_ELEMS = 8;   // element fields on the result channel

  // Up to two element writes per cycle, plus a reload of the identity.
  typedef struct packed {
    logic              load_ident;
    logic              wa_en;
    logic [IDX_W-1:0]  wa_addr;
    logic [ELEM_W-1:0] wa_data;
    logic              wb_en;
    logic [IDX_W-1:0]  wb_addr;
    logic [ELEM_W-1:0] wb_data;
  } wr_cmd_t;

  typedef enum logic [7:0] {
    ST_IDLE      = 8'b0000_0001,
    ST_SUCC      = 8'b0000_0010,
    ST_SWAP      = 8'b0000_0100,
    ST_REV_RD    = 8'b0000_1000,
    ST_REV_WR    = 8'b0001_0000,
    ST_PIV_PRIME = 8'b0010_0000,
    ST_PIV_SCAN  = 8'b0100_0000,
    ST_DONE      = 8'b1000_0000
  } state_t;

endpackage

// ----- rtl/lexicographic_permutation_generator.sv -----
// ----------------------------------------------------------------------------
// lexicographic_permutation_generator: next-permutation request engine
// Emits permutations of 0..n-1 in lexicographic order, one per request item.
// ----------------------------------------------------------------------------
// Each input item is a request: restart=1 returns the identity with rank 0,
// restart=0 returns the lexicographic successor of the permutation held, with
// the rank one higher; after the descending permutation it wraps to the
// identity. Positions at or beyond n read zero; is_last flags the descending
// permutation. A restart (or a next request before any restart, or right
// after a perm_size write) loads the identity without any scan. A successor
// request is run by a small sequencer around one 3-bit comparator and a
// single read port of the element register file: a successor scan, a swap,
// the suffix reversal (a read and a write state per swapped pair), and a
// pivot scan of the new permutation that also yields is_last and the pivot
// for the following request, then a load of the result register. in_ready
// is high only while the sequencer is idle; a finished result waits in the
// output register, so the next request can be taken while the previous
// result is still waiting. If that next result finishes while the output
// register is still full, the sequencer holds in its last state and
// in_ready stays low until the result is taken. perm_size may be written
// only while idle; values 0 and above MAX_ELEMS clamp to 1 and MAX_ELEMS.
module lexicographic_permutation_generator #(
  parameter int MAX_ELEMS = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [lpg_pkg::SIZE_W-1:0]          cfg_wr_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                restart,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [lpg_pkg::ELEM_W-1:0]          elem_0,
  output logic [lpg_pkg::ELEM_W-1:0]          elem_1,
  output logic [lpg_pkg::ELEM_W-1:0]          elem_2,
  output logic [lpg_pkg::ELEM_W-1:0]          elem_3,
  output logic [lpg_pkg::ELEM_W-1:0]          elem_4,
  output logic [lpg_pkg::ELEM_W-1:0]          elem_5,
  output logic [lpg_pkg::ELEM_W-1:0]          elem_6,
  output logic [lpg_pkg::ELEM_W-1:0]          elem_7,
  output logic [lpg_pkg::RANK_W-1:0]          perm_index,
  output logic                                is_last
);

  localparam int EW = lpg_pkg::ELEM_W;
  localparam int IW = lpg_pkg::IDX_W;
  localparam int SW = lpg_pkg::SIZE_W;
  localparam int NO = lpg_pkg::NUM_OUT_ELEMS;

  lpg_pkg::state_t  state;
  lpg_pkg::wr_cmd_t cmd;

  logic [SW-1:0]             perm_size;
  logic                      started;
  logic [lpg_pkg::RANK_W-1:0] rank;

  // Pivot of the held permutation: rightmost ascent, its value, and whether
  // one exists at all (none means the permutation is the descending one).
  logic [IW-1:0] piv_k;
  logic [EW-1:0] piv_val;
  logic          piv_found;

  logic [IW-1:0] a_idx;
  logic [IW-1:0] b_idx;
  logic [IW-1:0] l_idx;
  logic [EW-1:0] l_val;
  logic [EW-1:0] prev;
  logic [EW-1:0] tmp;

  logic [IW-1:0] rd_addr;
  logic [EW-1:0] rd_data;
  logic [EW-1:0] elems [MAX_ELEMS];

  logic [EW-1:0] out_elem [NO];
  logic [EW-1:0] elem_sel [NO];
  logic [lpg_pkg::RANK_W-1:0] out_rank;
  logic          out_last;

  logic [SW-1:0] n_eff;
  logic [IW-1:0] n_m1;
  logic [IW-1:0] n_m2;
  logic          in_fire;
  logic          out_free;

  // Shared comparator and its operand selection.
  logic [EW-1:0] cmp_a;
  logic [EW-1:0] cmp_b;
  logic          cmp_lt;

  // Clamp the configured size into 1..MAX_ELEMS.
  always_comb begin
    if (perm_size == '0) begin
      n_eff = SW'(1);
    end else if (perm_size > SW'(MAX_ELEMS)) begin
      n_eff = SW'(MAX_ELEMS);
    end else begin
      n_eff = perm_size;
    end
  end

  assign n_m1     = IW'(n_eff - SW'(1));
  assign n_m2     = IW'(n_eff - SW'(2));
  assign in_ready = (state == lpg_pkg::ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    if (state == lpg_pkg::ST_SUCC) begin
      cmp_a = piv_val;
      cmp_b = rd_data;
    end else begin
      cmp_a = rd_data;
      cmp_b = prev;
    end
  end
  assign cmp_lt = (cmp_a < cmp_b);

  // Read address and write command per state.
  always_comb begin
    cmd     = '0;
    rd_addr = a_idx;
    unique case (state)
      lpg_pkg::ST_IDLE: begin
        cmd.load_ident = in_fire && (restart || !started || !piv_found);
      end
      lpg_pkg::ST_SWAP: begin
        cmd.wa_en   = 1'b1;
        cmd.wa_addr = piv_k;
        cmd.wa_data = l_val;
        cmd.wb_en   = 1'b1;
        cmd.wb_addr = l_idx;
        cmd.wb_data = piv_val;
      end
      lpg_pkg::ST_REV_WR: begin
        rd_addr     = b_idx;
        cmd.wa_en   = 1'b1;
        cmd.wa_addr = a_idx;
        cmd.wa_data = rd_data;
        cmd.wb_en   = 1'b1;
        cmd.wb_addr = b_idx;
        cmd.wb_data = tmp;
      end
      lpg_pkg::ST_PIV_PRIME: begin
        rd_addr = n_m1;
      end
      lpg_pkg::ST_SUCC, lpg_pkg::ST_REV_RD, lpg_pkg::ST_PIV_SCAN,
      lpg_pkg::ST_DONE: begin
        rd_addr = a_idx;
      end
      default: begin
        rd_addr = a_idx;
      end
    endcase
  end

  lpg_perm_file #(
    .MAX_ELEMS(MAX_ELEMS)
  ) u_perm_file (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .elems   (elems)
  );

  // Mask positions at or beyond n; fields past MAX_ELEMS are tied to zero.
  for (genvar j = 0; j < NO; j++) begin : g_sel
    if (j < MAX_ELEMS) begin : g_live
      assign elem_sel[j] = (SW'(j) < n_eff) ? elems[j] : '0;
    end else begin : g_zero
      assign elem_sel[j] = '0;
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lpg_pkg::ST_IDLE;
      perm_size <= SW'(8);
      started   <= 1'b0;
      rank      <= '0;
      piv_found <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        perm_size <= cfg_wr_data;
        started   <= 1'b0;
      end
      unique case (state)
        lpg_pkg::ST_IDLE: begin
          if (in_fire) begin
            if (restart || !started || !piv_found) begin
              // Identity: pivot is known without a scan.
              started   <= 1'b1;
              rank      <= '0;
              piv_k     <= n_m2;
              piv_val   <= EW'(n_m2);
              piv_found <= (n_eff >= SW'(2));
              state     <= lpg_pkg::ST_DONE;
            end else begin
              a_idx <= n_m1;
              state <= lpg_pkg::ST_SUCC;
            end
          end
        end
        lpg_pkg::ST_SUCC: begin
          // Suffix right of the pivot is descending: first hit from the right.
          if (cmp_lt) begin
            l_idx <= a_idx;
            l_val <= rd_data;
            state <= lpg_pkg::ST_SWAP;
          end else begin
            a_idx <= a_idx - IW'(1);
          end
        end
        lpg_pkg::ST_SWAP: begin
          rank  <= rank + lpg_pkg::RANK_W'(1);
          a_idx <= piv_k + IW'(1);
          b_idx <= n_m1;
          if ((piv_k + IW'(1)) < n_m1) begin
            state <= lpg_pkg::ST_REV_RD;
          end else begin
            state <= lpg_pkg::ST_PIV_PRIME;
          end
        end
        lpg_pkg::ST_REV_RD: begin
          tmp   <= rd_data;
          state <= lpg_pkg::ST_REV_WR;
        end
        lpg_pkg::ST_REV_WR: begin
          a_idx <= a_idx + IW'(1);
          b_idx <= b_idx - IW'(1);
          if (({1'b0, a_idx} + 4'd1) < ({1'b0, b_idx} - 4'd1)) begin
            state <= lpg_pkg::ST_REV_RD;
          end else begin
            state <= lpg_pkg::ST_PIV_PRIME;
          end
        end
        lpg_pkg::ST_PIV_PRIME: begin
          prev  <= rd_data;
          a_idx <= n_m2;
          state <= lpg_pkg::ST_PIV_SCAN;
        end
        lpg_pkg::ST_PIV_SCAN: begin
          // Walk left for the rightmost ascent of the new permutation.
          if (cmp_lt) begin
            piv_found <= 1'b1;
            piv_k     <= a_idx;
            piv_val   <= rd_data;
            state     <= lpg_pkg::ST_DONE;
          end else if (a_idx == '0) begin
            piv_found <= 1'b0;
            state     <= lpg_pkg::ST_DONE;
          end else begin
            prev  <= rd_data;
            a_idx <= a_idx - IW'(1);
          end
        end
        lpg_pkg::ST_DONE: begin
          // Hold until the result register is free, then load it.
          if (out_free) begin
            state <= lpg_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= lpg_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // Result valid: set on load, drop once the item is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == lpg_pkg::ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (state == lpg_pkg::ST_DONE && out_free) begin
      out_elem <= elem_sel;
      out_rank <= rank;
      out_last <= !piv_found;
    end
  end

  assign elem_0     = out_elem[0];
  assign elem_1     = out_elem[1];
  assign elem_2     = out_elem[2];
  assign elem_3     = out_elem[3];
  assign elem_4     = out_elem[4];
  assign elem_5     = out_elem[5];
  assign elem_6     = out_elem[6];
  assign elem_7     = out_elem[7];
  assign perm_index = out_rank;
  assign is_last    = out_last;

`ifndef SYNTH
  // The successor scan never reaches the pivot position.
  a_succ_above_pivot: assert property (@(posedge clk) disable iff (rst)
    (state == lpg_pkg::ST_SUCC) |-> (a_idx > piv_k))
    else $error("successor scan passed the pivot");

  // Reversal pointers have not crossed while swapping.
  a_rev_ordered: assert property (@(posedge clk) disable iff (rst)
    (state == lpg_pkg::ST_REV_WR) |-> (a_idx < b_idx))
    else $error("suffix reversal pointers crossed");

  // A restart request always comes back with rank zero.
  a_restart_rank: assert property (@(posedge clk) disable iff (rst)
    (in_fire && restart) |=> (rank == '0))
    else $error("restart did not clear the rank");

  // A held pivot lies left of the last position.
  a_pivot_range: assert property (@(posedge clk) disable iff (rst)
    (state == lpg_pkg::ST_IDLE && started && piv_found) |-> (piv_k < n_m1))
    else $error("pivot outside the permutation");
`endif

endmodule

// ----- rtl/lpg_perm_file.sv -----
// ----------------------------------------------------------------------------
// lpg_perm_file: permutation element register file
// One indexed read port, two write ports, and a reload of the identity by
// clearing every per-entry valid bit. All entries also appear in parallel.
// ----------------------------------------------------------------------------
module lpg_perm_file #(
  parameter int MAX_ELEMS = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  lpg_pkg::wr_cmd_t              cmd,
  input  logic [lpg_pkg::IDX_W-1:0]     rd_addr,
  output logic [lpg_pkg::ELEM_W-1:0]    rd_data,
  output logic [lpg_pkg::ELEM_W-1:0]    elems [MAX_ELEMS]
);

  localparam int AW = $clog2(MAX_ELEMS);

  logic [lpg_pkg::ELEM_W-1:0] data [MAX_ELEMS];
  logic [MAX_ELEMS-1:0]       valid;

  // An entry that is not valid holds its own position (identity).
  for (genvar i = 0; i < MAX_ELEMS; i++) begin : g_entry
    assign elems[i] = valid[i] ? data[i] : lpg_pkg::ELEM_W'(i);

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[i] <= 1'b0;
      end else if (cmd.load_ident) begin
        valid[i] <= 1'b0;
      end else if ((cmd.wa_en && cmd.wa_addr[AW-1:0] == AW'(i)) ||
                   (cmd.wb_en && cmd.wb_addr[AW-1:0] == AW'(i))) begin
        valid[i] <= 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (cmd.wa_en && cmd.wa_addr[AW-1:0] == AW'(i)) begin
        data[i] <= cmd.wa_data;
      end else if (cmd.wb_en && cmd.wb_addr[AW-1:0] == AW'(i)) begin
        data[i] <= cmd.wb_data;
      end
    end
  end

  assign rd_data = elems[rd_addr[AW-1:0]];

endmodule
